FILE: rtl/bba_pkg.sv
// Package for the byte-to-block aligner: sizes, codes and shared types.
// Used by bba_fill, bba_emit and the top level; depends on nothing else.

package bba_pkg;

    // Block geometry (BLOCK_BYTES is a power of two, at least 16)
    localparam int BLOCK_BYTES  = 512;
    localparam int ADDRESS_BITS = 40;

    // Field widths of the beats
    localparam int OFFSET_W = 40;
    localparam int BYTE_W   = 8;
    localparam int WIDX_W   = 6;
    localparam int WORD_W   = 64;

    // Derived sizes
    localparam int AW        = (ADDRESS_BITS < OFFSET_W) ? ADDRESS_BITS : OFFSET_W;
    localparam int OFF_BITS  = $clog2(BLOCK_BYTES);
    localparam int FILL_BITS = OFF_BITS + 1;
    localparam int BLK_BITS  = AW - OFF_BITS;
    localparam int WORDS     = BLOCK_BYTES / 8;
    localparam int WSEL_BITS = OFF_BITS - 3;
    localparam int WCNT_BITS = WSEL_BITS + 1;

    // Operation codes on the input tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Result kinds on the output tuser
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ERR  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_WAIT
    } t_fill_state;

    // Request from the fill control to the emitter
    typedef struct packed {
        logic blk;   // stream the current block out
        logic err;   // send one rejected-write beat
    } t_emit_req;

    // Emitter status back to the fill control
    typedef struct packed {
        logic busy;  // block words still in flight
        logic rdy;   // a request can be taken this cycle
    } t_emit_sts;

    // Current block as seen by the emitter; held stable while busy
    typedef struct packed {
        logic [BLK_BITS-1:0]  base;     // block number
        logic [WSEL_BITS-1:0] asm_idx;  // word held in the assembly register
        logic [WORD_W-1:0]    asm_word; // partially filled word
        logic [WORDS-1:0]     wmap;     // words written back to the RAM
    } t_blk_view;

endpackage

FILE: rtl/bba_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.

module bba_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bba_fill.sv
// Fill control: takes one item, checks order, assembles bytes into 64-bit words
// and writes finished words to the block RAM. Uses bba_pkg.

module bba_fill (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item input
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [bba_pkg::OFFSET_W-1:0]    i_addr,
    input  logic [bba_pkg::BYTE_W-1:0]      i_byte,
    // block RAM write port
    output logic                            o_we,
    output logic [bba_pkg::WSEL_BITS-1:0]   o_waddr,
    output logic [bba_pkg::WORD_W-1:0]      o_wdata,
    // emitter
    output bba_pkg::t_emit_req              o_req,
    input  bba_pkg::t_emit_sts              i_sts,
    output bba_pkg::t_blk_view              o_view
);

    localparam int OB = bba_pkg::OFF_BITS;
    localparam int WB = bba_pkg::WSEL_BITS;
    localparam int FB = bba_pkg::FILL_BITS;

    bba_pkg::t_fill_state r_state, n_state;

    // held item
    logic                        r_op;
    logic [bba_pkg::AW-1:0]      r_addr;
    logic [bba_pkg::BYTE_W-1:0]  r_data;

    // block state
    logic [FB-1:0]                 r_fill, n_fill;
    logic [bba_pkg::BLK_BITS-1:0]  r_base, n_base;
    logic [bba_pkg::WORD_W-1:0]    r_asm, n_asm;
    logic [WB-1:0]                 r_asm_idx, n_asm_idx;
    logic [bba_pkg::WORDS-1:0]     r_wmap, n_wmap;
    logic                          r_done, n_done;
    logic                          r_emitted, n_emitted;

    // item decode
    logic [bba_pkg::BLK_BITS-1:0] a_blk;
    logic [OB-1:0]                a_off;
    logic [WB-1:0]                a_wo;
    logic [2:0]                   a_ln;
    logic [bba_pkg::WORD_W-1:0]   a_lane;
    logic                         has_blk;
    logic                         is_full;
    logic                         same_blk;
    logic                         backward;
    logic                         off_last;
    logic                         do_store;
    logic                         store_new;
    logic                         go;

    assign a_blk    = r_addr[bba_pkg::AW-1:OB];
    assign a_off    = r_addr[OB-1:0];
    assign a_wo     = a_off[OB-1:3];
    assign a_ln     = a_off[2:0];
    assign a_lane   = bba_pkg::WORD_W'(r_data) << {a_ln, 3'b000};
    assign has_blk  = (r_fill != '0);
    assign is_full  = r_fill[OB];
    assign same_blk = (a_blk == r_base);
    assign backward = (a_blk < r_base) || (same_blk && (FB'(a_off) < r_fill));
    assign off_last = (a_off == {OB{1'b1}});

    assign o_ready = (r_state == bba_pkg::S_IDLE);

    // next state and block update
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_done    = r_done;
        n_emitted = r_emitted;
        o_req     = '0;
        do_store  = 1'b0;
        store_new = 1'b0;
        go        = 1'b0;
        case (r_state)
            bba_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_done    = 1'b0;
                    n_emitted = 1'b0;
                    n_state   = bba_pkg::S_PROC;
                end
            end
            bba_pkg::S_PROC: begin
                if (is_full) begin
                    // full block held over from the last item goes first
                    if (i_sts.rdy) begin
                        o_req.blk = 1'b1;
                        n_fill    = '0;
                        n_emitted = 1'b1;
                        n_state   = bba_pkg::S_WAIT;
                    end
                end else if (r_op == bba_pkg::OP_FLUSH) begin
                    if (!has_blk) begin
                        n_state = bba_pkg::S_IDLE;
                    end else if (i_sts.rdy) begin
                        o_req.blk = 1'b1;
                        n_fill    = '0;
                        n_done    = 1'b1;
                        n_state   = bba_pkg::S_WAIT;
                    end
                end else if (has_blk && backward) begin
                    if (i_sts.rdy) begin
                        o_req.err = 1'b1;
                        n_state   = bba_pkg::S_IDLE;
                    end
                end else if (has_blk && same_blk) begin
                    go = !off_last || i_sts.rdy;
                    if (go) begin
                        do_store = 1'b1;
                        if (off_last) begin
                            o_req.blk = 1'b1;
                            n_fill    = '0;
                            n_done    = 1'b1;
                            n_state   = bba_pkg::S_WAIT;
                        end else begin
                            n_fill  = FB'(a_off) + FB'(1);
                            n_state = bba_pkg::S_IDLE;
                        end
                    end
                end else if (has_blk) begin
                    // byte in a later block: close the current one first
                    if (i_sts.rdy) begin
                        o_req.blk = 1'b1;
                        n_fill    = '0;
                        n_emitted = 1'b1;
                        n_state   = bba_pkg::S_WAIT;
                    end
                end else begin
                    // no block held: start one at the byte's own block
                    go = !(off_last && !r_emitted) || i_sts.rdy;
                    if (go) begin
                        do_store  = 1'b1;
                        store_new = 1'b1;
                        n_fill    = FB'(a_off) + FB'(1);
                        n_state   = bba_pkg::S_IDLE;
                        if (off_last && !r_emitted) begin
                            o_req.blk = 1'b1;
                            n_fill    = '0;
                            n_done    = 1'b1;
                            n_state   = bba_pkg::S_WAIT;
                        end
                    end
                end
            end
            bba_pkg::S_WAIT: begin
                if (!i_sts.busy) begin
                    n_state = r_done ? bba_pkg::S_IDLE : bba_pkg::S_PROC;
                end
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    // byte placement into the assembly word, write-back of a finished word
    always_comb begin
        n_base    = r_base;
        n_asm     = r_asm;
        n_asm_idx = r_asm_idx;
        n_wmap    = r_wmap;
        o_we      = 1'b0;
        o_waddr   = r_asm_idx;
        o_wdata   = r_asm;
        if (do_store) begin
            if (store_new) begin
                n_base    = a_blk;
                n_wmap    = '0;
                n_asm     = a_lane;
                n_asm_idx = a_wo;
            end else if (a_wo == r_asm_idx) begin
                n_asm = r_asm | a_lane;
            end else begin
                o_we              = 1'b1;
                n_wmap[r_asm_idx] = 1'b1;
                n_asm             = a_lane;
                n_asm_idx         = a_wo;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bba_pkg::S_IDLE;
            r_fill    <= '0;
            r_base    <= '0;
            r_wmap    <= '0;
            r_done    <= 1'b0;
            r_emitted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_base    <= n_base;
            r_wmap    <= n_wmap;
            r_done    <= n_done;
            r_emitted <= n_emitted;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_asm     <= n_asm;
        r_asm_idx <= n_asm_idx;
        if (i_valid && o_ready) begin
            r_op   <= i_op;
            r_addr <= i_addr[bba_pkg::AW-1:0];
            r_data <= i_byte;
        end
    end

    assign o_view.base     = r_base;
    assign o_view.asm_idx  = r_asm_idx;
    assign o_view.asm_word = r_asm;
    assign o_view.wmap     = r_wmap;

endmodule

FILE: rtl/bba_emit.sv
// Emitter: reads the block RAM word by word, fills holes with zeros and drives
// the registered result beat. Uses bba_pkg.

module bba_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // from fill control
    input  bba_pkg::t_emit_req                i_req,
    output bba_pkg::t_emit_sts                o_sts,
    input  bba_pkg::t_blk_view                i_view,
    // block RAM read port
    output logic                              o_re,
    output logic [bba_pkg::WSEL_BITS-1:0]     o_raddr,
    input  logic [bba_pkg::WORD_W-1:0]        i_rdata,
    // result beat
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_kind,
    output logic [bba_pkg::OFFSET_W-1:0]      o_baddr,
    output logic [bba_pkg::WIDX_W-1:0]        o_widx,
    output logic [bba_pkg::WORD_W-1:0]        o_word,
    output logic                              o_last
);

    localparam int WB = bba_pkg::WSEL_BITS;
    localparam int CB = bba_pkg::WCNT_BITS;

    logic                          r_busy, n_busy;
    logic [CB-1:0]                 r_cnt, n_cnt;
    logic                          r_s1v, n_s1v;
    logic [WB-1:0]                 r_s1w;
    logic                          r_ov, n_ov;
    logic                          r_kind;
    logic [bba_pkg::OFFSET_W-1:0]  r_baddr;
    logic [bba_pkg::WIDX_W-1:0]    r_widx;
    logic [bba_pkg::WORD_W-1:0]    r_word;
    logic                          r_last;

    logic                          out_free;
    logic                          s1_adv;
    logic                          issue;
    logic [bba_pkg::WORD_W-1:0]    s1_word;

    assign out_free = !r_ov || i_ready;
    assign s1_adv   = r_s1v && out_free;
    assign issue    = r_busy && !r_cnt[WB] && (!r_s1v || s1_adv);

    assign o_re    = issue;
    assign o_raddr = r_cnt[WB-1:0];

    assign o_sts.busy = r_busy;
    assign o_sts.rdy  = !r_busy && out_free;

    // word as sent: assembly word, written word or zero padding
    always_comb begin
        if (r_s1w == i_view.asm_idx) begin
            s1_word = i_view.asm_word;
        end else if (i_view.wmap[r_s1w]) begin
            s1_word = i_rdata;
        end else begin
            s1_word = '0;
        end
    end

    // read sequencing and beat valid
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_s1v  = r_s1v;
        n_ov   = r_ov;
        if (i_req.blk) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end
        if (issue) begin
            n_cnt = r_cnt + CB'(1);
        end
        if (r_busy && r_cnt[WB] && (!r_s1v || s1_adv)) begin
            n_busy = 1'b0;
        end
        if (issue) begin
            n_s1v = 1'b1;
        end else if (s1_adv) begin
            n_s1v = 1'b0;
        end
        if (s1_adv || i_req.err) begin
            n_ov = 1'b1;
        end else if (i_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_s1v  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_s1v  <= n_s1v;
            r_ov   <= n_ov;
        end
    end

    // read stage index and result beat payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1w <= r_cnt[WB-1:0];
        end
        if (s1_adv) begin
            r_kind  <= bba_pkg::KIND_DATA;
            r_baddr <= bba_pkg::OFFSET_W'({i_view.base, {bba_pkg::OFF_BITS{1'b0}}});
            r_widx  <= bba_pkg::WIDX_W'(r_s1w);
            r_word  <= s1_word;
            r_last  <= (r_s1w == WB'(bba_pkg::WORDS - 1));
        end else if (i_req.err) begin
            r_kind  <= bba_pkg::KIND_ERR;
            r_baddr <= '0;
            r_widx  <= '0;
            r_word  <= '0;
            r_last  <= 1'b1;
        end
    end

    assign o_valid = r_ov;
    assign o_kind  = r_kind;
    assign o_baddr = r_baddr;
    assign o_widx  = r_widx;
    assign o_word  = r_word;
    assign o_last  = r_last;

endmodule

FILE: rtl/byte_to_block_padding_aligner_top.sv
// Top level of the byte-to-block aligner: stream ports, block RAM, fill and emit.
// Depends on bba_pkg, bba_ram, bba_fill and bba_emit.

// Bytes tagged with an address are gathered into aligned 512-byte blocks, held
// as 64 words of 64 bits in one block RAM; a flush (tuser high) pads the open
// block with zeros and sends it. A byte item is captured and then placed by one
// read-modify-write of the assembly word. A block goes out at one word a cycle
// from the RAM read port when the result side does not stall, and an item may
// first have to push out a full block left by the previous item. A backward
// write gives a single beat with tuser high and tlast high. No input beat is
// taken while a block is being sent.

module byte_to_block_padding_aligner_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [47:0]  i_s_tdata,   // byte_offset[39:0], data_byte[47:40]
    input  logic         i_s_tuser,   // op
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [111:0] o_m_tdata,   // block_address[39:0], word_index[45:40],
                                      // data_word[109:46], zero[111:110]
    output logic         o_m_tuser,   // kind
    output logic         o_m_tlast    // last_word
);

    bba_pkg::t_emit_req  req;
    bba_pkg::t_emit_sts  sts;
    bba_pkg::t_blk_view  view;

    logic                            ram_we;
    logic [bba_pkg::WSEL_BITS-1:0]   ram_waddr;
    logic [bba_pkg::WORD_W-1:0]      ram_wdata;
    logic                            ram_re;
    logic [bba_pkg::WSEL_BITS-1:0]   ram_raddr;
    logic [bba_pkg::WORD_W-1:0]      ram_rdata;

    logic [bba_pkg::OFFSET_W-1:0]    out_baddr;
    logic [bba_pkg::WIDX_W-1:0]      out_widx;
    logic [bba_pkg::WORD_W-1:0]      out_word;

    bba_ram #(
        .DEPTH (bba_pkg::WORDS),
        .WIDTH (bba_pkg::WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser),
        .i_addr  (i_s_tdata[39:0]),
        .i_byte  (i_s_tdata[47:40]),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_req   (req),
        .i_sts   (sts),
        .o_view  (view)
    );

    bba_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_sts   (sts),
        .i_view  (view),
        .o_re    (ram_re),
        .o_raddr (ram_raddr),
        .i_rdata (ram_rdata),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (o_m_tuser),
        .o_baddr (out_baddr),
        .o_widx  (out_widx),
        .o_word  (out_word),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, out_word, out_widx, out_baddr};

    // a rejected write is always a single, final beat
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == bba_pkg::KIND_ERR) |-> o_m_tlast)
        else $error("error beat without tlast");

    // no input beat is taken while a block is streaming out
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.busy |-> !o_s_tready)
        else $error("input ready while block emission busy");

    // an accepted beat is always followed by a processing cycle
    a_accept_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second input beat taken without processing");

endmodule
